/* design/three_wire_rtc_serial_master_core_assert.svh */
// assertion macros for the three-wire rtc serial master core
// expects a clock named clk and an active-high reset named rst in the including module
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_CORE_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RTCSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RTCSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/rtcsm_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the three-wire rtc serial master core
// no dependencies
package rtcsm_pkg;

  localparam int DT_BYTES_MAX     = 7;
  localparam int DT_WIDTH         = 8 * DT_BYTES_MAX;
  localparam int DATETIME_BYTES_DEF = 7;

  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH   = 4;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_LOW = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_LOW  = 2'd1;

  localparam logic [3:0] WRITE_LOW_RST = 4'd3;
  localparam logic [3:0] READ_LOW_RST  = 4'd5;

  // request codes
  localparam logic [1:0] FN_IDLE     = 2'd0;
  localparam logic [1:0] FN_STATUS   = 2'd1;
  localparam logic [1:0] FN_DT_READ  = 2'd2;
  localparam logic [1:0] FN_DT_WRITE = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_STATUS   = 8'h63;
  localparam logic [7:0] CMD_DT_READ  = 8'h65;
  localparam logic [7:0] CMD_DT_WRITE = 8'h64;

  // pin levels: bit0 sck, bit1 sio, bit2 cs
  localparam logic [2:0] PINS_IDLE  = 3'b001;
  localparam logic [2:0] PINS_START = 3'b101;
  localparam logic [2:0] DIR_ALL    = 3'b111;
  localparam logic [2:0] DIR_SIO_IN = 3'b101;

  localparam int STATUS_CLOCK_BIT = 6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_CMD,
    PH_READ,
    PH_WRITE
  } phase_t;

  typedef struct packed {
    logic [3:0] write_low;
    logic [3:0] read_low;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          pin_levels;
    logic [2:0]          pin_direction;
    logic                port_enable;
    logic                busy;
    logic                done;
    logic [DT_WIDTH-1:0] date_time;
    logic [7:0]          status_byte;
    logic                clock_present;
  } res_t;

endpackage

/* design/rtcsm_cfg_regs.sv */
`timescale 1ns / 1ps
// configuration registers: sck-low slot counts for sending and receiving
// depends on rtcsm_pkg
module rtcsm_cfg_regs import rtcsm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  output cfg_t                       cfg
);

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.write_low <= WRITE_LOW_RST;
      regs.read_low  <= READ_LOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WRITE_LOW: regs.write_low <= cfg_data;
        REG_READ_LOW:  regs.read_low  <= cfg_data;
        default:       ;
      endcase
    end
  end

endmodule

/* design/rtcsm_step.sv */
`timescale 1ns / 1ps
// transaction sequencer: one port slot per beat, holds the transaction state
// depends on rtcsm_pkg
module rtcsm_step import rtcsm_pkg::*; #(
  parameter int DATETIME_BYTES = DATETIME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [1:0]          func,
  input  logic [DT_WIDTH-1:0] write_data,
  input  logic                sio_in,
  input  cfg_t                cfg,
  output res_t                res
);

  phase_t              phase, phase_next;
  logic [1:0]          kind, kind_next;
  logic [3:0]          slot_count, slot_count_next;
  logic [2:0]          bit_index, bit_index_next;
  logic [2:0]          byte_index, byte_index_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [DT_WIDTH-1:0] write_latch, write_latch_next;
  logic [DT_WIDTH-1:0] read_gather, read_gather_next;
  logic [7:0]          status_hold, status_hold_next;
  logic                enable_hold, enable_hold_next;

  logic [3:0]          low_reg, low_eff;
  logic                sck_high, last_bit, dt_last, done;
  logic [2:0]          byte_inc;
  logic [7:0]          cmd_byte, sample;
  logic                cmd_bit, wr_bit;
  logic [DT_WIDTH+7:0] latch_ext;

  // zero low-slot count behaves as one
  assign low_reg  = (phase == PH_READ) ? cfg.read_low : cfg.write_low;
  assign low_eff  = (low_reg == 4'd0) ? 4'd1 : low_reg;
  assign sck_high = !(slot_count < low_eff);
  assign last_bit = (bit_index == 3'd7);
  assign byte_inc = byte_index + 3'd1;
  assign dt_last  = (byte_inc >= 3'(DATETIME_BYTES)) || (byte_inc == 3'd0);

  always_comb begin
    case (kind)
      FN_DT_WRITE: cmd_byte = CMD_DT_WRITE;
      FN_STATUS:   cmd_byte = CMD_STATUS;
      default:     cmd_byte = CMD_DT_READ;
    endcase
  end

  // command goes msb first, data lsb first
  assign cmd_bit   = cmd_byte[3'd7 - bit_index];
  assign latch_ext = {8'd0, write_latch};
  assign wr_bit    = latch_ext[{byte_index, bit_index}];
  assign sample    = shift_byte | (8'(sio_in) << bit_index);

  assign done = sck_high && last_bit &&
                (((phase == PH_READ) && ((kind == FN_STATUS) || dt_last)) ||
                 ((phase == PH_WRITE) && dt_last));

  // next state
  always_comb begin
    phase_next       = phase;
    kind_next        = kind;
    slot_count_next  = slot_count;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    shift_byte_next  = shift_byte;
    write_latch_next = write_latch;
    read_gather_next = read_gather;
    status_hold_next = status_hold;
    enable_hold_next = enable_hold;
    case (phase)
      PH_START: begin
        phase_next = PH_CMD;
      end
      PH_CMD, PH_READ, PH_WRITE: begin
        if (!sck_high) begin
          slot_count_next = slot_count + 4'd1;
        end else begin
          slot_count_next = 4'd0;
          if (phase == PH_READ) begin
            shift_byte_next = sample;
          end
          if (!last_bit) begin
            bit_index_next = bit_index + 3'd1;
          end else begin
            bit_index_next = 3'd0;
            case (phase)
              PH_CMD: begin
                shift_byte_next = 8'd0;
                phase_next = (kind == FN_DT_WRITE) ? PH_WRITE : PH_READ;
              end
              PH_READ: begin
                shift_byte_next = 8'd0;
                if (kind == FN_STATUS) begin
                  status_hold_next = sample;
                end else begin
                  for (int i = 0; i < DT_BYTES_MAX; i++) begin
                    if (byte_index == 3'(i)) begin
                      read_gather_next[8*i +: 8] = sample;
                    end
                  end
                  byte_index_next = byte_inc;
                end
              end
              default: begin
                byte_index_next = byte_inc;
              end
            endcase
          end
        end
        if (done) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (func != FN_IDLE) begin
          kind_next = func;
          if (func == FN_DT_WRITE) begin
            write_latch_next = write_data;
          end
          if (func != FN_DT_READ) begin
            enable_hold_next = 1'b1;
          end
          slot_count_next = 4'd0;
          bit_index_next  = 3'd0;
          byte_index_next = 3'd0;
          shift_byte_next = 8'd0;
          phase_next      = PH_START;
        end
      end
    endcase
  end

  // slot outputs
  always_comb begin
    res.pin_levels    = PINS_IDLE;
    res.pin_direction = DIR_ALL;
    res.busy          = 1'b1;
    res.done          = done;
    res.port_enable   = enable_hold_next;
    res.date_time     = read_gather_next;
    res.status_byte   = status_hold_next;
    res.clock_present = status_hold_next[STATUS_CLOCK_BIT];
    case (phase)
      PH_START: res.pin_levels = PINS_START;
      PH_CMD:   res.pin_levels = {1'b1, cmd_bit, sck_high};
      PH_READ: begin
        res.pin_levels    = {1'b1, 1'b0, sck_high};
        res.pin_direction = DIR_SIO_IN;
      end
      PH_WRITE: res.pin_levels = {1'b1, wr_bit, sck_high};
      default:  res.busy = (func != FN_IDLE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      kind        <= FN_IDLE;
      slot_count  <= 4'd0;
      bit_index   <= 3'd0;
      byte_index  <= 3'd0;
      shift_byte  <= 8'd0;
      write_latch <= '0;
      read_gather <= '0;
      status_hold <= 8'd0;
      enable_hold <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      kind        <= kind_next;
      slot_count  <= slot_count_next;
      bit_index   <= bit_index_next;
      byte_index  <= byte_index_next;
      shift_byte  <= shift_byte_next;
      write_latch <= write_latch_next;
      read_gather <= read_gather_next;
      status_hold <= status_hold_next;
      enable_hold <= enable_hold_next;
    end
  end

endmodule

/* design/three_wire_rtc_serial_master_core.sv */
`timescale 1ns / 1ps
// three-wire rtc serial master core: input register, slot sequencer, result register
// depends on rtcsm_pkg, rtcsm_cfg_regs, rtcsm_step and the assertion macro header
//
//   channel  handshake              payload
//   req      req_valid / req_stall  func, write_data, sio_in
//   res      res_valid / res_stall  pin_levels .. clock_present
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat per clock sustained while res_stall is low; a result passes from its request beat
// through the input register, then the sequencer logic, into the result register
// the sequencer state steps once per beat as it moves into the result register
// synchronous reset clears control and sequencer state; cfg_ready is always high
// res_stall holds the result register, and req_stall rises only once the input
// register also holds a beat
module three_wire_rtc_serial_master_core import rtcsm_pkg::*; #(
  parameter int DATETIME_BYTES = DATETIME_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [1:0]                 func,
  input  logic [DT_WIDTH-1:0]        write_data,
  input  logic                       sio_in,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [2:0]                 pin_levels,
  output logic [2:0]                 pin_direction,
  output logic                       port_enable,
  output logic                       busy_res,
  output logic                       done_res,
  output logic [DT_WIDTH-1:0]        date_time,
  output logic [7:0]                 status_byte,
  output logic                       clock_present,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  `include "three_wire_rtc_serial_master_core_assert.svh"

  cfg_t                cfg;
  logic                in_full;
  logic [1:0]          in_func;
  logic [DT_WIDTH-1:0] in_wdata;
  logic                in_sio;
  logic                advance;
  logic                req_take;
  res_t                step_res;
  res_t                res_q;

  rtcsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a held beat moves on whenever the result register is free or draining
  assign advance   = in_full && (!res_valid || !res_stall);
  assign req_stall = in_full && res_valid && res_stall;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      in_func  <= func;
      in_wdata <= write_data;
      in_sio   <= sio_in;
    end
  end

  rtcsm_step #(
    .DATETIME_BYTES (DATETIME_BYTES)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .func       (in_func),
    .write_data (in_wdata),
    .sio_in     (in_sio),
    .cfg        (cfg),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign pin_levels    = res_q.pin_levels;
  assign pin_direction = res_q.pin_direction;
  assign port_enable   = res_q.port_enable;
  assign busy_res      = res_q.busy;
  assign done_res      = res_q.done;
  assign date_time     = res_q.date_time;
  assign status_byte   = res_q.status_byte;
  assign clock_present = res_q.clock_present;

  `RTCSM_ASSERT_IMPL(a_stall_cause, req_stall, res_valid && res_stall && in_full, "input stalled without a held result")
  `RTCSM_ASSERT_IMPL(a_done_busy, res_valid && done_res, busy_res, "done on a slot that is not busy")
  `RTCSM_ASSERT_IMPL(a_clock_bit, res_valid, clock_present == status_byte[STATUS_CLOCK_BIT], "clock bit disagrees with status")
  `RTCSM_ASSERT_NEXT(a_advance_out, advance, res_valid, "advanced beat did not reach the result register")

endmodule
